// ===== src/mstb_pkg.sv =====
// Package for the multi-slot countdown timer bank: codes, limits and the
// command record passed from the front end through the queue to the back end.
// No dependencies.
package mstb_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int RESULT_LIMIT   = 16;
    localparam int REP_W          = $clog2(RESULT_LIMIT + 1);

    localparam logic [15:0] STOPPED_VALUE = 16'hFFFF;
    localparam logic [7:0]  OWNER_INVALID = 8'hFF;

    typedef enum logic [2:0] {
        ACT_ALLOC       = 3'd0,
        ACT_CLOSE       = 3'd1,
        ACT_SET_TIMEOUT = 3'd2,
        ACT_START       = 3'd3,
        ACT_STOP        = 3'd4,
        ACT_TICK        = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NO_SLOT = 2'd2
    } status_t;

    // Classified command: bad marks anything rejectable without slot state.
    typedef struct packed {
        action_t     kind;
        logic        bad;
        logic [3:0]  idx;
        logic [15:0] tmo;
        logic [7:0]  owner;
    } cmd_t;

endpackage

// ===== src/mstb_front.sv =====
// Front end: decodes an input item into a command record and flags argument
// errors that need no slot state. Depends on mstb_pkg.
module mstb_front #(
    parameter int SLOT_COUNT = mstb_pkg::SLOT_COUNT_DEF
) (
    input  logic [2:0]      action,
    input  logic [3:0]      slot_index,
    input  logic [15:0]     timeout_ms,
    input  logic [7:0]      owner_tag,
    output mstb_pkg::cmd_t  cmd
);
    import mstb_pkg::*;

    logic idx_ok;

    assign idx_ok = (32'(slot_index) < SLOT_COUNT);

    always_comb
    begin
        cmd.kind  = ACT_CLOSE;
        cmd.bad   = 1'b0;
        cmd.idx   = slot_index;
        cmd.tmo   = timeout_ms;
        cmd.owner = owner_tag;
        unique case (action)
            ACT_ALLOC:
            begin
                cmd.kind = ACT_ALLOC;
                cmd.bad  = (owner_tag == OWNER_INVALID);
            end
            ACT_CLOSE:
            begin
                cmd.kind = ACT_CLOSE;
                cmd.bad  = !idx_ok;
            end
            ACT_SET_TIMEOUT:
            begin
                cmd.kind = ACT_SET_TIMEOUT;
                cmd.bad  = !idx_ok || (timeout_ms == 16'd0) || (timeout_ms == STOPPED_VALUE);
            end
            ACT_START:
            begin
                cmd.kind = ACT_START;
                cmd.bad  = !idx_ok;
            end
            ACT_STOP:
            begin
                cmd.kind = ACT_STOP;
                cmd.bad  = !idx_ok;
            end
            ACT_TICK:
            begin
                cmd.kind = ACT_TICK;
            end
            default:
            begin
                // unknown action: one invalid result
                cmd.bad = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/mstb_queue.sv =====
// Short command queue between front and back end.
// Depends on mstb_pkg.
module mstb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mstb_pkg::cmd_t  push_cmd,
    output logic            full,
    output logic            not_empty,
    input  logic            pop,
    output mstb_pkg::cmd_t  head
);
    import mstb_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/mstb_back.sv =====
// Back end: slot state, timeout/countdown/owner memories, the one-slot-per-cycle
// walk for allocate and tick unless stalled, the result register. Uses mstb_pkg.
module mstb_back #(
    parameter int SLOT_COUNT = mstb_pkg::SLOT_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  mstb_pkg::cmd_t  q_head,
    output logic            q_pop,
    output logic            result_valid,
    input  logic            result_stall,
    output logic [1:0]      status,
    output logic [3:0]      result_slot,
    output logic            expired,
    output logic [7:0]      expired_owner,
    output logic            last
);
    import mstb_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMD   = 5'b00010,
        S_FIND  = 5'b00100,
        S_WALK  = 5'b01000,
        S_FLUSH = 5'b10000
    } bstate_t;

    bstate_t          state_reg, state_next;
    logic [SW-1:0]    cnt_reg, cnt_next;
    logic [REP_W-1:0] rep_reg, rep_next;
    cmd_t             cmd_reg, cmd_next;
    logic [SLOT_COUNT-1:0] in_use_reg, in_use_next;

    logic             pend_valid_reg, pend_valid_next;
    logic [3:0]       pend_slot_reg, pend_slot_next;
    logic [7:0]       pend_owner_reg, pend_owner_next;

    // slot memories, read data registered
    logic [15:0]      tmo_mem [SLOT_COUNT];
    logic [15:0]      rem_mem [SLOT_COUNT];
    logic [7:0]       own_mem [SLOT_COUNT];
    logic [15:0]      tmo_rd_reg, rem_rd_reg;
    logic [7:0]       own_rd_reg;
    logic [SW-1:0]    rd_addr;
    logic             tmo_we, rem_we, own_we;
    logic [SW-1:0]    tmo_wa, rem_wa, own_wa;
    logic [15:0]      tmo_wd, rem_wd;
    logic [7:0]       own_wd;

    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [3:0]       out_slot_reg;
    logic             out_exp_reg;
    logic [7:0]       out_owner_reg;
    logic             out_last_reg;

    logic             emit;
    status_t          e_status;
    logic [3:0]       e_slot;
    logic             e_exp;
    logic [7:0]       e_owner;
    logic             e_last;

    logic             out_free;
    logic [SW-1:0]    cmd_addr, head_addr;
    logic [SW+3:0]    cnt_wide;
    logic [15:0]      rem_dec;
    logic             at_last;

    assign out_free  = !out_valid_reg || !result_stall;
    assign cmd_addr  = SW'(cmd_reg.idx);
    assign head_addr = SW'(q_head.idx);
    assign cnt_wide  = (SW + 4)'(cnt_reg);
    assign rem_dec   = rem_rd_reg - 16'd1;
    assign at_last   = (cnt_reg == LAST_SLOT);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rep_next        = rep_reg;
        cmd_next        = cmd_reg;
        in_use_next     = in_use_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_owner_next = pend_owner_reg;
        q_pop           = 1'b0;
        rd_addr         = cnt_reg;
        emit            = 1'b0;
        e_status        = ST_OK;
        e_slot          = '0;
        e_exp           = 1'b0;
        e_owner         = '0;
        e_last          = 1'b1;
        tmo_we          = 1'b0;
        tmo_wa          = cnt_reg;
        tmo_wd          = cmd_reg.tmo;
        rem_we          = 1'b0;
        rem_wa          = cnt_reg;
        rem_wd          = STOPPED_VALUE;
        own_we          = 1'b0;
        own_wa          = cnt_reg;
        own_wd          = cmd_reg.owner;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = head_addr;
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    cnt_next = '0;
                    rep_next = '0;
                    if (q_head.bad)
                    begin
                        state_next = S_CMD;
                    end
                    else if (q_head.kind == ACT_ALLOC)
                    begin
                        state_next = S_FIND;
                    end
                    else if (q_head.kind == ACT_TICK)
                    begin
                        state_next = S_WALK;
                        rd_addr    = '0;
                    end
                    else
                    begin
                        state_next = S_CMD;
                    end
                end
            end
            S_CMD:
            begin
                rd_addr = cmd_addr;
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (cmd_reg.bad || !in_use_reg[cmd_addr])
                    begin
                        e_status = ST_INVALID;
                    end
                    else
                    begin
                        case (cmd_reg.kind)
                            ACT_CLOSE:
                            begin
                                in_use_next[cmd_addr] = 1'b0;
                            end
                            ACT_SET_TIMEOUT:
                            begin
                                tmo_we = 1'b1;
                                tmo_wa = cmd_addr;
                            end
                            ACT_START:
                            begin
                                rem_we = 1'b1;
                                rem_wa = cmd_addr;
                                rem_wd = tmo_rd_reg;
                            end
                            ACT_STOP:
                            begin
                                rem_we = 1'b1;
                                rem_wa = cmd_addr;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_FIND:
            begin
                // lowest free slot, one slot per cycle
                if (!in_use_reg[cnt_reg])
                begin
                    if (out_free)
                    begin
                        emit                 = 1'b1;
                        e_slot               = cnt_wide[3:0];
                        in_use_next[cnt_reg] = 1'b1;
                        tmo_we               = 1'b1;
                        rem_we               = 1'b1;
                        own_we               = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
                else if (at_last)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_status   = ST_NO_SLOT;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WALK:
            begin
                // read data holds slot cnt_reg; stall holds the address
                if (out_free)
                begin
                    rd_addr = at_last ? cnt_reg : cnt_reg + 1'b1;
                    if (in_use_reg[cnt_reg] && (rem_rd_reg != STOPPED_VALUE))
                    begin
                        rem_we = 1'b1;
                        if (rem_dec == 16'd0)
                        begin
                            if (rep_reg < REP_W'(RESULT_LIMIT))
                            begin
                                // previous expiry is now known not to be last
                                if (pend_valid_reg)
                                begin
                                    emit    = 1'b1;
                                    e_slot  = pend_slot_reg;
                                    e_exp   = 1'b1;
                                    e_owner = pend_owner_reg;
                                    e_last  = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_slot_next  = cnt_wide[3:0];
                                pend_owner_next = own_rd_reg;
                                rep_next        = rep_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            // zero countdown wraps to the stopped value here
                            rem_wd = rem_dec;
                        end
                    end
                    if (at_last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    emit            = 1'b1;
                    e_slot          = pend_slot_reg;
                    e_exp           = 1'b1;
                    e_owner         = pend_owner_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rep_reg        <= '0;
            in_use_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rep_reg        <= rep_next;
            in_use_reg     <= in_use_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pend_slot_reg  <= pend_slot_next;
        pend_owner_reg <= pend_owner_next;
        if (emit)
        begin
            out_status_reg <= e_status;
            out_slot_reg   <= e_slot;
            out_exp_reg    <= e_exp;
            out_owner_reg  <= e_owner;
            out_last_reg   <= e_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tmo_we)
        begin
            tmo_mem[tmo_wa] <= tmo_wd;
        end
        if (rem_we)
        begin
            rem_mem[rem_wa] <= rem_wd;
        end
        if (own_we)
        begin
            own_mem[own_wa] <= own_wd;
        end
        tmo_rd_reg <= tmo_mem[rd_addr];
        rem_rd_reg <= rem_mem[rd_addr];
        own_rd_reg <= own_mem[rd_addr];
    end

    assign result_valid  = out_valid_reg;
    assign status        = out_status_reg;
    assign result_slot   = out_slot_reg;
    assign expired       = out_exp_reg;
    assign expired_owner = out_owner_reg;
    assign last          = out_last_reg;

endmodule

// ===== src/multi_slot_countdown_timer_bank_unit.sv =====
// Top level of the multi-slot countdown timer bank: front decoder, command
// queue and back end. Depends on mstb_pkg, mstb_front, mstb_queue, mstb_back.
//
// Usage:
//  - Item channel (item_valid/item_stall): one command per transfer:
//    allocate, close, set timeout, start, stop or tick. item_stall is high
//    only while the two-entry command queue is full.
//  - Result channel (result_valid/result_stall): every command but tick gives
//    one result with last set. A tick gives one result per expiring slot in
//    ascending slot order (at most 16), last on the final one, and no result
//    at all when nothing expires.
//  - Back end: close, set timeout, start, stop and rejected commands pass
//    through S_IDLE and S_CMD. Allocate scans slots one per cycle. A tick
//    walks every slot one per cycle through the countdown memory while
//    results are not stalled. The back end works on one command at a
//    time; sustained rate is set by that slot walk.
//  - Reset: all slots free and stopped at once; slot memories need no clear
//    since a slot is only read while in use, after allocate wrote it.
//  - Stall: a result waits in the output register while result_stall is high;
//    the back end holds its walk, and new commands keep filling the queue.
module multi_slot_countdown_timer_bank_unit #(
    parameter int SLOT_COUNT = mstb_pkg::SLOT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  action,
    input  logic [3:0]  slot_index,
    input  logic [15:0] timeout_ms,
    input  logic [7:0]  owner_tag,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [3:0]  result_slot,
    output logic        expired,
    output logic [7:0]  expired_owner,
    output logic        last
);
    import mstb_pkg::*;

    cmd_t front_cmd;   // decoded command entering the queue
    cmd_t q_head;      // oldest queued command
    logic q_full;
    logic q_valid;
    logic q_pop;

    mstb_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .action     (action),
        .slot_index (slot_index),
        .timeout_ms (timeout_ms),
        .owner_tag  (owner_tag),
        .cmd        (front_cmd)
    );

    // full is registered state, so stall never depends on valid
    assign item_stall = q_full;

    mstb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_valid),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (q_pop),
        .head      (q_head)
    );

    mstb_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .result_slot   (result_slot),
        .expired       (expired),
        .expired_owner (expired_owner),
        .last          (last)
    );

endmodule

// ===== src/mstb_checker.sv =====
// Port-level checks for the timer bank, bound to the top level.
// Depends on mstb_pkg and multi_slot_countdown_timer_bank_unit.
module mstb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic [1:0] status,
    input logic [3:0] result_slot,
    input logic       expired,
    input logic [7:0] expired_owner,
    input logic       last
);
    import mstb_pkg::*;

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("stalled result dropped");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(status) && $stable(result_slot)
            && $stable(expired) && $stable(expired_owner) && $stable(last))
        else $error("stalled result changed");

    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && expired |-> status == ST_OK)
        else $error("expiry result with error status");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !expired |-> last && expired_owner == 8'd0)
        else $error("command result not single or carries owner");

endmodule

bind multi_slot_countdown_timer_bank_unit mstb_checker u_mstb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .result_slot   (result_slot),
    .expired       (expired),
    .expired_owner (expired_owner),
    .last          (last)
);

// ===== verif/timer_bank_scoreboard_pkg.sv =====
// Scoreboard for the timer bank testbench: a shadow slot table that predicts
// status and expiry results, and the queue of results still awaited.
// Depends on mstb_pkg.
package timer_bank_scoreboard_pkg;
    import mstb_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;

    typedef struct {
        status_t    status;
        logic [3:0] slot;
        logic       expired;
        logic [7:0] owner;
        logic       last;
    } timer_result_t;

    class timer_bank_scoreboard;
        bit            in_use   [SLOTS];
        logic [15:0]   timeout  [SLOTS];
        logic [15:0]   remaining[SLOTS];
        logic [7:0]    owner    [SLOTS];
        timer_result_t awaited[$];
        int            errors;

        function new();
            for (int s = 0; s < SLOTS; s++)
            begin
                in_use[s]    = 1'b0;
                timeout[s]   = '0;
                remaining[s] = STOPPED_VALUE;
                owner[s]     = '0;
            end
            errors = 0;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        function void push(status_t st, logic [3:0] sl, logic ex, logic [7:0] ow, logic la);
            timer_result_t r;
            r = '{st, sl, ex, ow, la};
            awaited.push_back(r);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted command to the shadow table.
        function void note_command(logic [2:0] act, logic [3:0] idx, logic [15:0] tmo,
                                   logic [7:0] tag);
            int found;
            int fired;
            bit target_ok;
            found     = -1;
            fired     = 0;
            target_ok = (int'(idx) < SLOTS) && in_use[idx];
            case (act)
                ACT_ALLOC:
                begin
                    if (tag == OWNER_INVALID)
                        push(ST_INVALID, 4'd0, 1'b0, 8'd0, 1'b1);
                    else
                    begin
                        for (int s = SLOTS - 1; s >= 0; s--)
                            if (!in_use[s])
                                found = s;
                        if (found < 0)
                            push(ST_NO_SLOT, 4'd0, 1'b0, 8'd0, 1'b1);
                        else
                        begin
                            in_use[found]    = 1'b1;
                            timeout[found]   = tmo;
                            remaining[found] = STOPPED_VALUE;
                            owner[found]     = tag;
                            push(ST_OK, 4'(found), 1'b0, 8'd0, 1'b1);
                        end
                    end
                end
                ACT_CLOSE:
                begin
                    if (!target_ok)
                        push(ST_INVALID, 4'd0, 1'b0, 8'd0, 1'b1);
                    else
                    begin
                        in_use[idx]    = 1'b0;
                        timeout[idx]   = '0;
                        remaining[idx] = STOPPED_VALUE;
                        owner[idx]     = OWNER_INVALID;
                        push(ST_OK, 4'd0, 1'b0, 8'd0, 1'b1);
                    end
                end
                ACT_SET_TIMEOUT:
                begin
                    if (!target_ok || tmo == 16'd0 || tmo == STOPPED_VALUE)
                        push(ST_INVALID, 4'd0, 1'b0, 8'd0, 1'b1);
                    else
                    begin
                        timeout[idx] = tmo;
                        push(ST_OK, 4'd0, 1'b0, 8'd0, 1'b1);
                    end
                end
                ACT_START, ACT_STOP:
                begin
                    if (!target_ok)
                        push(ST_INVALID, 4'd0, 1'b0, 8'd0, 1'b1);
                    else
                    begin
                        remaining[idx] = (act == ACT_START) ? timeout[idx] : STOPPED_VALUE;
                        push(ST_OK, 4'd0, 1'b0, 8'd0, 1'b1);
                    end
                end
                ACT_TICK:
                begin
                    // a started zero timeout wraps to stopped here with no report
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (in_use[s] && remaining[s] != STOPPED_VALUE)
                        begin
                            remaining[s] = remaining[s] - 16'd1;
                            if (remaining[s] == 16'd0)
                            begin
                                remaining[s] = STOPPED_VALUE;
                                if (fired < RESULT_LIMIT)
                                begin
                                    push(ST_OK, 4'(s), 1'b1, owner[s], 1'b0);
                                    fired++;
                                end
                            end
                        end
                    end
                    if (fired > 0)
                        awaited[awaited.size() - 1].last = 1'b1;
                end
                default:
                    push(ST_INVALID, 4'd0, 1'b0, 8'd0, 1'b1);
            endcase
        endfunction

        task check_result(timer_result_t got);
            timer_result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("result with none awaited: status %0d slot %0d",
                                 got.status, got.slot));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.slot !== want.slot)
                report($sformatf("result_slot %0d, want %0d", got.slot, want.slot));
            if (got.expired !== want.expired)
                report($sformatf("expired %b, want %b", got.expired, want.expired));
            if (got.owner !== want.owner)
                report($sformatf("expired_owner %0d, want %0d", got.owner, want.owner));
            if (got.last !== want.last)
                report($sformatf("last %b, want %b", got.last, want.last));
        endtask
    endclass

endpackage

// ===== verif/multi_slot_countdown_timer_bank_unit_tb.sv =====
// Top-level testbench for the multi-slot countdown timer bank: directed and
// random command streams, random idling on both channels, a long result hold.
// Depends on mstb_pkg, timer_bank_scoreboard_pkg and the timer bank RTL.
module multi_slot_countdown_timer_bank_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mstb_pkg::*;
    import timer_bank_scoreboard_pkg::*;

    // Watchdog bound, with lots of slack over the slowest legal run.
    localparam int CYCLE_LIMIT  = 500_000;
    // Long result hold: far more than the queue plus output register can absorb.
    localparam int HOLD_CYCLES  = 300;
    // After the last awaited result up to two ticks can still sit in the
    // queue and one in the back end, each walking every slot.
    localparam int DRAIN_CYCLES = 3 * (SLOTS + 2) + 10;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic [2:0]  action       = '0;
    logic [3:0]  slot_index   = '0;
    logic [15:0] timeout_ms   = '0;
    logic [7:0]  owner_tag    = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  status;
    logic [3:0]  result_slot;
    logic        expired;
    logic [7:0]  expired_owner;
    logic        last;

    timer_bank_scoreboard sb = new();

    // Idle odds in percent, per phase. Receiver hold is requested by token.
    int gap_pct    = 0;
    int stall_pct  = 0;
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int cycle_count = 0;

    multi_slot_countdown_timer_bank_unit dut (.*);

    always #6 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver side. A hold request stalls the result channel for a long
    // stretch so results back up, the command queue fills and item_stall
    // rises; otherwise stall follows the phase odds.
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_pct > 0)
            result_stall <= ($urandom_range(99) < stall_pct);
        else
            result_stall <= 1'b0;
    end

    // Result monitor: values read here are the ones present before the edge,
    // so a transfer is exactly valid high with stall low.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(timer_result_t'{status_t'(status), result_slot, expired,
                                             expired_owner, last});
    end

    // Offer one command, idling first at the phase odds, and hand it to the
    // scoreboard once the transfer has taken place. The payload is held
    // while item_stall is high.
    task automatic issue_cmd(logic [2:0] act, logic [3:0] idx, logic [15:0] tmo,
                             logic [7:0] tag);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        action     <= act;
        slot_index <= idx;
        timeout_ms <= tmo;
        owner_tag  <= tag;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_command(act, idx, tmo, tag);
    endtask

    // Mostly aim at live slots so commands get past the in-use check.
    function automatic logic [3:0] pick_slot();
        int live[$];
        for (int s = 0; s < SLOTS; s++)
            if (sb.in_use[s])
                live.push_back(s);
        if (live.size() != 0 && $urandom_range(99) < 85)
            return 4'(live[$urandom_range(live.size() - 1)]);
        return 4'($urandom_range(15));
    endfunction

    // Short timeouts dominate so expiries are common; zero and the stopped
    // value show up often enough to hit their special handling.
    function automatic logic [15:0] pick_timeout();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'd0;
        if (r < 15)
            return STOPPED_VALUE;
        if (r < 75)
            return 16'($urandom_range(6, 1));
        if (r < 90)
            return 16'($urandom_range(40, 7));
        return 16'($urandom);
    endfunction

    task automatic random_cmd();
        int r;
        logic [7:0] tag;
        r = $urandom_range(99);
        if (r < 18)
        begin
            tag = ($urandom_range(19) == 0) ? OWNER_INVALID : 8'($urandom);
            issue_cmd(ACT_ALLOC, 4'($urandom), pick_timeout(), tag);
        end
        else if (r < 28)
            issue_cmd(ACT_CLOSE, pick_slot(), 16'($urandom), 8'($urandom));
        else if (r < 40)
            issue_cmd(ACT_SET_TIMEOUT, pick_slot(), pick_timeout(), 8'($urandom));
        else if (r < 60)
            issue_cmd(ACT_START, pick_slot(), 16'($urandom), 8'($urandom));
        else if (r < 66)
            issue_cmd(ACT_STOP, pick_slot(), 16'($urandom), 8'($urandom));
        else if (r < 97)
            issue_cmd(ACT_TICK, 4'($urandom), 16'($urandom), 8'($urandom));
        else
            issue_cmd(3'($urandom_range(7, 6)), 4'($urandom), 16'($urandom),
                      8'($urandom));
    endtask

    // Fill the bank, arm every slot with the same timeout and tick until they
    // all fire together: sixteen expiry results from one tick.
    task automatic fill_and_fire(logic [15:0] tmo);
        for (int s = 0; s < SLOTS; s++)
            if (!sb.in_use[s])
                issue_cmd(ACT_ALLOC, 4'($urandom), 16'($urandom), 8'($urandom_range(254)));
        for (int s = 0; s < SLOTS; s++)
        begin
            issue_cmd(ACT_SET_TIMEOUT, 4'(s), tmo, 8'($urandom));
            issue_cmd(ACT_START, 4'(s), 16'($urandom), 8'($urandom));
        end
        repeat (int'(tmo) + 1)
            issue_cmd(ACT_TICK, 4'($urandom), 16'($urandom), 8'($urandom));
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bad targets on an empty bank, owner rejection, timeout
        // rejection, a zero timeout wrapping silently, a stopped-value
        // timeout never running, the unknown actions and slot reuse.
        issue_cmd(ACT_TICK,        4'd0,  16'd0,      8'd0);
        issue_cmd(ACT_CLOSE,       4'd3,  16'd0,      8'd0);
        issue_cmd(ACT_START,       4'd0,  16'd0,      8'd0);
        issue_cmd(ACT_STOP,        4'd15, 16'hFFFF,   8'hFF);
        issue_cmd(ACT_SET_TIMEOUT, 4'd5,  16'd5,      8'd0);
        issue_cmd(ACT_ALLOC,       4'd0,  16'd7,      OWNER_INVALID);
        issue_cmd(ACT_ALLOC,       4'd0,  16'd1,      8'd0);
        issue_cmd(ACT_ALLOC,       4'd0,  16'd0,      8'd254);
        issue_cmd(ACT_ALLOC,       4'd0,  STOPPED_VALUE, 8'hA5);
        issue_cmd(ACT_SET_TIMEOUT, 4'd0,  16'd0,      8'd0);
        issue_cmd(ACT_SET_TIMEOUT, 4'd0,  STOPPED_VALUE, 8'd0);
        issue_cmd(ACT_SET_TIMEOUT, 4'd0,  16'd2,      8'd0);
        issue_cmd(ACT_START,       4'd0,  16'd0,      8'd0);
        issue_cmd(ACT_START,       4'd1,  16'd0,      8'd0);
        issue_cmd(ACT_START,       4'd2,  16'd0,      8'd0);
        issue_cmd(ACT_TICK,        4'd0,  16'd0,      8'd0);
        issue_cmd(ACT_TICK,        4'd0,  16'd0,      8'd0);
        issue_cmd(ACT_START,       4'd0,  16'd0,      8'd0);
        issue_cmd(ACT_STOP,        4'd0,  16'd0,      8'd0);
        issue_cmd(ACT_TICK,        4'd0,  16'd0,      8'd0);
        issue_cmd(3'd6,            4'd9,  16'h5A5A,   8'h3C);
        issue_cmd(3'd7,            4'd6,  16'hA5A5,   8'hC3);
        issue_cmd(ACT_CLOSE,       4'd2,  16'd0,      8'd0);
        issue_cmd(ACT_CLOSE,       4'd2,  16'd0,      8'd0);
        issue_cmd(ACT_ALLOC,       4'd0,  16'd1,      8'd1);

        // Random phases: clean, sender gaps, receiver stalls, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 84; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 84; end
                default: begin gap_pct = 23; stall_pct = 23; end
            endcase
            if (ph == 0 || ph == 2)
                fill_and_fire((ph == 0) ? 16'd3 : 16'd1);
            repeat (60)
                random_cmd();
            if (ph == 1)
            begin
                // Back-pressure: hold results while commands keep coming,
                // every one of which produces a status result.
                gap_pct = 0;
                hold_token++;
                repeat (24)
                    issue_cmd(($urandom_range(1) != 0) ? ACT_START : ACT_STOP, pick_slot(),
                              16'($urandom), 8'($urandom));
            end
        end
        item_valid <= 1'b0;

        // Drain: everything awaited, then room for ticks that fire nothing,
        // so a stray result still gets caught.
        gap_pct   = 0;
        stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/mstb_pkg.sv
src/mstb_front.sv
src/mstb_queue.sv
src/mstb_back.sv
src/multi_slot_countdown_timer_bank_unit.sv
src/mstb_checker.sv
verif/timer_bank_scoreboard_pkg.sv
verif/multi_slot_countdown_timer_bank_unit_tb.sv
